FILE: sv/bfa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bit-field buffer access block.
// No dependencies; imported by the top level, the checker and the testbench.
package bfa_pkg;

  localparam int BUF_BYTES      = 32;
  localparam int MAX_FIELD_BITS = 16;
  localparam int BYTE_BITS      = 8;
  localparam int BUF_BITS       = BUF_BYTES * BYTE_BITS;

  localparam int START_W = 8;
  localparam int LEN_W   = 5;
  localparam int VAL_W   = 16;
  localparam int SUM_W   = START_W + 1;

  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = BUF_BITS / WORD_BITS;
  localparam int BANK_DEPTH = (NUM_WORDS + 1) / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int OFS_W      = $clog2(WORD_BITS);
  localparam int WIDX_W     = START_W - OFS_W;
  localparam int PAIR_W     = 2 * WORD_BITS;
  localparam int PIDX_W     = $clog2(PAIR_W);

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [START_W-1:0] start_bit;
    logic [LEN_W-1:0]   field_len;
    logic [VAL_W-1:0]   write_value;
  } bfa_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    range_error;
  } bfa_out_t;

endpackage

FILE: sv/bit_field_buffer_access.sv
`timescale 1ns / 1ps
// Top level of the bit-field buffer access block.
// Depends on bfa_pkg and bfa_ram.
//
// Usage:
//   Present a transaction on in_data and raise start; it is taken at a rising
//   edge where start is high and busy is low. mode selects a field read or a
//   field write of field_len bits (saturated to 16) at start_bit, LSB first.
//   Each transaction produces exactly one result on out_data, marked by
//   out_strobe for one cycle; the receiver cannot stall it.
//   The result passes the s1_vld_r and s2_vld_r registers, then out_strobe and
//   out_data are registered together.
//   A new transaction is not taken while busy is high; busy is high for the cycle in
//   which the two buffer words are read. The buffer is split into even and odd
//   32-bit words in two RAM banks, so any field is covered by one read of each
//   bank, merged and written back in the following cycle. A write-back register
//   per bank forwards the newest word to the next transaction.
//   Out-of-range accesses raise range_error, return zero and change nothing.
//   Reset (rst_n low, synchronous) empties the pipeline and marks every buffer
//   word as zero through per-word valid bits; no clearing pass is needed.
module bit_field_buffer_access
  import bfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bfa_in_t  in_data,
  output logic     out_strobe,
  output bfa_out_t out_data
);

  logic                 s1_vld_r, s2_vld_r, out_strobe_r;
  bfa_out_t             out_data_r, out_data_nxt;
  logic                 mode_r, err_r, par_r;
  logic [LEN_W-1:0]     len_r;
  logic [OFS_W-1:0]     ofs_r;
  logic [VAL_W-1:0]     wval_r;
  logic [BANK_AW-1:0]   a0_r, a1_r;
  logic [BANK_DEPTH-1:0] v0_r, v1_r;
  logic                 byp0_vld_r, byp1_vld_r;
  logic [BANK_AW-1:0]   byp0_addr_r, byp1_addr_r;
  logic [WORD_BITS-1:0] byp0_data_r, byp1_data_r;

  logic                 accept;
  logic [LEN_W-1:0]     len_sat;
  logic                 err_nxt;
  logic [WIDX_W-1:0]    widx;
  logic [BANK_AW-1:0]   a0_nxt, a1_nxt;
  logic [WORD_BITS-1:0] dout0, dout1, e0, e1, lo_w, hi_w, wd0, wd1;
  logic [PAIR_W-1:0]    pair, raw, lmask, fmask, field, rd_ext, ins, newpair;
  logic [PIDX_W-1:0]    sign_idx;
  logic                 sign, we;

  assign busy   = s1_vld_r;
  assign accept = start && !busy;

  always_comb begin
    len_sat = (in_data.field_len > LEN_W'(MAX_FIELD_BITS)) ?
              LEN_W'(MAX_FIELD_BITS) : in_data.field_len;
    err_nxt = (SUM_W'(in_data.start_bit) + SUM_W'(len_sat)) > SUM_W'(BUF_BITS);
    widx    = in_data.start_bit[START_W-1:OFS_W];
    a1_nxt  = BANK_AW'(widx >> 1);
    a0_nxt  = BANK_AW'(({1'b0, widx} + (WIDX_W + 1)'(1)) >> 1);
  end

  bfa_ram #(.WIDTH(WORD_BITS), .DEPTH(BANK_DEPTH)) u_bank0 (
    .clk(clk), .we(we), .waddr(a0_r), .wdata(wd0),
    .re(accept), .raddr(a0_nxt), .rdata(dout0)
  );

  bfa_ram #(.WIDTH(WORD_BITS), .DEPTH(BANK_DEPTH)) u_bank1 (
    .clk(clk), .we(we), .waddr(a1_r), .wdata(wd1),
    .re(accept), .raddr(a1_nxt), .rdata(dout1)
  );

  // Merge forwarded, stored and never-written words, then extract and insert.
  always_comb begin
    if (byp0_vld_r && (byp0_addr_r == a0_r)) begin
      e0 = byp0_data_r;
    end else begin
      e0 = v0_r[a0_r] ? dout0 : '0;
    end
    if (byp1_vld_r && (byp1_addr_r == a1_r)) begin
      e1 = byp1_data_r;
    end else begin
      e1 = v1_r[a1_r] ? dout1 : '0;
    end
    lo_w     = par_r ? e1 : e0;
    hi_w     = par_r ? e0 : e1;
    pair     = {hi_w, lo_w};
    raw      = pair >> ofs_r;
    lmask    = (PAIR_W'(1) << len_r) - PAIR_W'(1);
    field    = raw & lmask;
    sign_idx = PIDX_W'(len_r - LEN_W'(1));
    sign     = (len_r != '0) && raw[sign_idx];
    rd_ext   = sign ? (field | ~lmask) : field;
    fmask    = lmask << ofs_r;
    ins      = ({{(PAIR_W - VAL_W){wval_r[VAL_W-1]}}, wval_r} << ofs_r) & fmask;
    newpair  = (pair & ~fmask) | ins;
    wd0      = par_r ? newpair[PAIR_W-1:WORD_BITS] : newpair[WORD_BITS-1:0];
    wd1      = par_r ? newpair[WORD_BITS-1:0] : newpair[PAIR_W-1:WORD_BITS];
    we       = s2_vld_r && (mode_r == MODE_WRITE) && !err_r;

    out_data_nxt.range_error = err_r;
    if ((mode_r == MODE_READ) && !err_r) begin
      out_data_nxt.read_value = rd_ext[VAL_W-1:0];
    end else begin
      out_data_nxt.read_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      v0_r         <= '0;
      v1_r         <= '0;
      byp0_vld_r   <= 1'b0;
      byp1_vld_r   <= 1'b0;
    end else begin
      s1_vld_r     <= accept;
      s2_vld_r     <= s1_vld_r;
      out_strobe_r <= s2_vld_r;
      if (we) begin
        v0_r[a0_r] <= 1'b1;
        v1_r[a1_r] <= 1'b1;
        byp0_vld_r <= 1'b1;
        byp1_vld_r <= 1'b1;
      end
    end
  end

  // Hold the transaction fields, the write-back words and the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_data.mode;
      len_r  <= len_sat;
      ofs_r  <= in_data.start_bit[OFS_W-1:0];
      par_r  <= widx[0];
      wval_r <= in_data.write_value;
      err_r  <= err_nxt;
      a0_r   <= a0_nxt;
      a1_r   <= a1_nxt;
    end
    if (we) begin
      byp0_addr_r <= a0_r;
      byp1_addr_r <= a1_r;
      byp0_data_r <= wd0;
      byp1_data_r <= wd1;
    end
    if (s2_vld_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> ##1 out_strobe)
    else $error("result missing two cycles after accept");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !s2_vld_r)
    else $error("result overlaps a write-back cycle");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.range_error |-> out_data.read_value == '0)
    else $error("nonzero read value on range error");

  a_write_stage: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> s2_vld_r && !err_r && !busy)
    else $error("buffer write outside the write-back cycle");

endmodule

FILE: sv/bfa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: bench/bfa_checker.sv
`timescale 1ns / 1ps
// Checker for the bit-field buffer access block: watches both channels, keeps a
// shadow of the byte buffer, predicts each result and compares. Depends on bfa_pkg.
module bfa_checker
  import bfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  bfa_in_t  in_data,
  input  logic     out_strobe,
  input  bfa_out_t out_data,
  output int       errors,
  output int       pending
);

  logic [BYTE_BITS-1:0] shadow [BUF_BYTES];
  bfa_out_t             expected_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report(string what, int got, int want);
    $display("%0t bfa_checker: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Apply one access to the shadow buffer and return the result it gives.
  function automatic bfa_out_t apply_access(bfa_in_t t);
    bfa_out_t         res;
    int               len;
    int               pos;
    logic [VAL_W-1:0] field;
    res   = '0;
    field = '0;
    len   = (t.field_len > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(t.field_len);
    if (int'(t.start_bit) + len > BUF_BITS) begin
      res.range_error = 1'b1;
      return res;
    end
    for (int i = 0; i < len; i++) begin
      pos = int'(t.start_bit) + i;
      if (t.mode == MODE_READ) begin
        field[i] = shadow[pos / BYTE_BITS][pos % BYTE_BITS];
      end else begin
        shadow[pos / BYTE_BITS][pos % BYTE_BITS] = t.write_value[i];
      end
    end
    if (t.mode == MODE_READ && len > 0 && field[len-1]) begin
      for (int i = len; i < VAL_W; i++) field[i] = 1'b1;
    end
    if (t.mode == MODE_READ) res.read_value = field;
    return res;
  endfunction

  always @(posedge clk) begin
    bfa_out_t want;
    if (!rst_n) begin
      foreach (shadow[i]) shadow[i] = '0;
      expected_q.delete();
    end else begin
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.read_value !== want.read_value)
            report("read_value", int'(out_data.read_value), int'(want.read_value));
          if (out_data.range_error !== want.range_error)
            report("range_error", int'(out_data.range_error), int'(want.range_error));
        end
      end
      if (start && !busy) expected_q.push_back(apply_access(in_data));
    end
    pending <= expected_q.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Testbench top for bit_field_buffer_access: drives directed and random field
// reads and writes in bursts, and reports the verdict. Depends on bfa_pkg, bfa_checker.
module tb
  import bfa_pkg::*;
();

  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 200000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  bfa_in_t  in_data;
  logic     out_strobe;
  bfa_out_t out_data;
  int       errors;
  int       pending;
  int       cycles;
  int       reads;
  int       writes;

  bit_field_buffer_access i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  bfa_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .errors     (errors),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic bfa_in_t field_access(logic mode, int sb, int len, int val);
    bfa_in_t t;
    t.mode        = mode;
    t.start_bit   = sb[START_W-1:0];
    t.field_len   = len[LEN_W-1:0];
    t.write_value = val[VAL_W-1:0];
    return t;
  endfunction

  // Present one transaction and hold it until it is taken.
  task automatic issue(bfa_in_t t);
    in_data <= t;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (t.mode == MODE_READ) reads++;
    else writes++;
  endtask

  task automatic idle(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    int      burst;
    int      sb;
    int      len;
    int      last_sb;
    int      last_len;
    int      pick;
    logic    mode;
    bfa_in_t t;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    reads    = 0;
    writes   = 0;
    last_sb  = 0;
    last_len = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, byte crossings, zero and overlong lengths, range limits
    issue(field_access(MODE_READ,    0,  1, 16'h0000));
    issue(field_access(MODE_READ,  240, 16, 16'hFFFF));
    issue(field_access(MODE_WRITE,   0, 16, 16'hFFFF));
    issue(field_access(MODE_READ,    0, 16, 16'h0000));
    issue(field_access(MODE_READ,    3,  1, 16'h0000));
    issue(field_access(MODE_WRITE,  13, 11, 16'h0555));
    issue(field_access(MODE_READ,   10, 16, 16'h0000));
    issue(field_access(MODE_WRITE, 100, 16, 16'h8000));
    issue(field_access(MODE_READ,  100, 16, 16'h0000));
    issue(field_access(MODE_READ,  115,  1, 16'h0000));
    issue(field_access(MODE_WRITE, 252,  4, 16'hFFFA));
    issue(field_access(MODE_READ,  255,  1, 16'h0000));
    issue(field_access(MODE_READ,  255,  2, 16'h0000));
    issue(field_access(MODE_WRITE, 241, 16, 16'hFFFF));
    issue(field_access(MODE_READ,  240, 16, 16'h0000));
    issue(field_access(MODE_WRITE, 250, 16, 16'hFFFF));
    issue(field_access(MODE_READ,  248,  8, 16'h0000));
    issue(field_access(MODE_WRITE,  40,  0, 16'hFFFF));
    issue(field_access(MODE_READ,   40,  0, 16'h0000));
    issue(field_access(MODE_READ,  256 - 0, 0, 16'h0000));
    issue(field_access(MODE_WRITE, 240, 31, 16'h7FFF));
    issue(field_access(MODE_READ,  240, 31, 16'h0000));
    issue(field_access(MODE_READ,  241, 31, 16'h0000));
    issue(field_access(MODE_WRITE, 255, 17, 16'h1234));
    issue(field_access(MODE_READ,    0, 16, 16'h0000));

    // random: reads and writes; some reads revisit the last written field, plus noise
    burst = $urandom_range(1, 12);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 9);
      mode = 1'($urandom_range(0, 1));
      if (pick < 3 && mode == MODE_READ) begin
        sb  = last_sb + $urandom_range(0, 2) - 1;
        len = last_len;
        if (sb < 0) sb = 0;
        if (sb > 255) sb = 255;
      end else begin
        len = (pick == 9) ? (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31))
                          : $urandom_range(1, 16);
        if (pick == 8) sb = 256 - ((len > MAX_FIELD_BITS) ? MAX_FIELD_BITS : len)
                            + $urandom_range(0, 1);
        else sb = $urandom_range(0, 255);
        if (sb > 255) sb = 255;
      end
      t = field_access(mode, sb, len, $urandom_range(0, 65535));
      if (mode == MODE_WRITE) begin
        last_sb  = sb;
        last_len = len;
      end
      issue(t);
      burst--;
      if (burst == 0) begin
        idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        burst = $urandom_range(1, 12);
      end
    end
    start <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("tb: %0d transactions: %0d field reads, %0d field writes", reads + writes,
             reads, writes);
    $display("tb: directed edges, byte crossings, zero/overlong lengths, range errors");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/bfa_pkg.sv
sv/bfa_ram.sv
sv/bit_field_buffer_access.sv
bench/bfa_checker.sv
bench/tb.sv
